### design/bce_pkg.sv
package bce_pkg;

  // Fixed widths of the arithmetic
  localparam int unsigned LABEL_W  = 17;
  localparam int unsigned PRED_W   = 24;
  localparam int unsigned MEAN_W   = 24;
  localparam int unsigned COUNT_W  = 21;
  localparam int unsigned SUM_W    = 42;
  localparam int unsigned PROB_W   = 24;
  localparam int unsigned TAB_W    = 25;
  localparam int unsigned PROD_W   = 40;
  localparam int unsigned LOSS_W   = 21;
  localparam int unsigned ACC_W    = 40;
  localparam int unsigned BIT_W    = 5;
  localparam int unsigned DIVCNT_W = 6;

  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned IDX_W         = 8;
  localparam int unsigned MAX_ELEMENTS  = 1048576;

  // Values of the logit mode register
  localparam logic MODE_PROB  = 1'b0;
  localparam logic MODE_LOGIT = 1'b1;

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_ELEMENTS);
  localparam logic [LABEL_W-1:0] LABEL_ONE = 17'd65536;
  localparam logic [TAB_W-1:0]   ONE_Q24   = 25'd16777216;
  localparam logic [TAB_W-1:0]   EPS_Q24   = 25'd2;
  localparam logic [TAB_W-1:0]   PMAX_Q24  = 25'd16777214;
  localparam logic [23:0]        LN2_Q24   = 24'd11629080;
  localparam logic [PRED_W-1:0]  SIG_SPAN  = 24'd1048576;

  typedef logic [TAB_W-1:0] tab_t [0:TABLE_ENTRIES];

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIG,
    ST_PROB,
    ST_NORM,
    ST_LMUL,
    ST_LFIN,
    ST_WMUL,
    ST_ACC,
    ST_DIV_INIT,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic sig;
    logic prob;
    logic norm;
    logic lmul;
    logic lfin;
    logic wmul;
    logic acc;
    logic mark_sat;
    logic div_init;
    logic div_step;
    logic emit;
    logic sel;
  } dp_cmd_t;

  typedef struct packed {
    logic count_full;
    logic last;
    logic out_free;
  } dp_status_t;

  // Shift-subtract long division, elaboration time only
  function automatic logic [63:0] cdiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + k/T) in Q0.24 through 2*atanh(k/(2T+k))
  function automatic logic [63:0] ln_entry(input logic [63:0] k);
    logic [63:0] z, z2, term, acc, n;
    z    = cdiv(k << 32, 64'(2 * TABLE_ENTRIES) + k);
    z2   = (z * z) >> 32;
    term = z;
    acc  = '0;
    n    = 64'd1;
    while (term != 0) begin
      acc  = acc + cdiv(term, n);
      term = (term * z2) >> 32;
      n    = n + 64'd2;
    end
    return (64'd2 * acc + 64'd128) >> 8;
  endfunction

  // 1/(1+e^-x) in Q0.24 at x = 16k/T
  function automatic logic [63:0] sig_entry(input logic [63:0] k);
    logic [63:0] y, y2, y3, y4, e, den, num;
    y  = (k << 27) / TABLE_ENTRIES;
    y2 = (y * y) >> 31;
    y3 = (y2 * y) >> 31;
    y4 = (y3 * y) >> 31;
    e  = 64'd2147483648 - y + y2 / 2 - y3 / 6 + y4 / 24;
    for (int i = 0; i < 8; i++) begin
      e = (e * e + (64'd1 << 30)) >> 31;
    end
    den = 64'd2147483648 + e;
    num = (64'd16777216 << 31) + den / 2;
    return cdiv(num, den);
  endfunction

  function automatic tab_t ln_table();
    tab_t t;
    for (int k = 0; k <= TABLE_ENTRIES; k++) begin
      t[k] = TAB_W'(ln_entry(64'(k)));
    end
    return t;
  endfunction

  function automatic tab_t sig_table();
    tab_t t;
    for (int k = 0; k <= TABLE_ENTRIES; k++) begin
      t[k] = TAB_W'(sig_entry(64'(k)));
    end
    return t;
  endfunction

  localparam tab_t LN_TAB  = ln_table();
  localparam tab_t SIG_TAB = sig_table();

endpackage

### design/bce_ctrl.sv
module bce_ctrl
  import bce_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e               state_q, state_d;
  logic                 sel_q, sel_d;
  logic [DIVCNT_W-1:0]  cnt_q, cnt_d;
  logic                 accept;

  assign accept = (state_q == ST_IDLE) && in_valid_i;

  // Advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_SIG;
      end
      ST_SIG: state_d = ST_PROB;
      ST_PROB: begin
        sel_d = 1'b0;
        if (!status_i.count_full) state_d = ST_NORM;
        else if (status_i.last)   state_d = ST_DIV_INIT;
        else                      state_d = ST_IDLE;
      end
      ST_NORM: state_d = ST_LMUL;
      ST_LMUL: state_d = ST_LFIN;
      ST_LFIN: state_d = ST_WMUL;
      ST_WMUL: begin
        if (!sel_q) begin
          sel_d   = 1'b1;
          state_d = ST_NORM;
        end else begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: state_d = status_i.last ? ST_DIV_INIT : ST_IDLE;
      ST_DIV_INIT: begin
        cnt_d   = DIVCNT_W'(SUM_W);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == DIVCNT_W'(1)) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o          = '0;
    cmd_o.sel      = sel_q;
    in_ready_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = accept;
      end
      ST_SIG:  cmd_o.sig = 1'b1;
      ST_PROB: begin
        cmd_o.prob     = 1'b1;
        cmd_o.mark_sat = status_i.count_full;
      end
      ST_NORM:     cmd_o.norm     = 1'b1;
      ST_LMUL:     cmd_o.lmul     = 1'b1;
      ST_LFIN:     cmd_o.lfin     = 1'b1;
      ST_WMUL:     cmd_o.wmul     = 1'b1;
      ST_ACC:      cmd_o.acc      = 1'b1;
      ST_DIV_INIT: cmd_o.div_init = 1'b1;
      ST_DIV:      cmd_o.div_step = 1'b1;
      ST_EMIT:     cmd_o.emit     = status_i.out_free;
      default: ;
    endcase
  end

endmodule

### design/bce_dp.sv
module bce_dp
  import bce_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_data_i,
  input  logic [LABEL_W-1:0]  label_i,
  input  logic [PRED_W-1:0]   prediction_i,
  input  logic                last_element_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [MEAN_W-1:0]   mean_loss_o,
  output logic [COUNT_W-1:0]  elements_seen_o,
  output logic                count_saturated_o,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          status_o
);

  logic                logit_q;
  logic [LABEL_W-1:0]  label_q;
  logic [PRED_W-1:0]   pred_q;
  logic                last_q;
  logic [TAB_W-1:0]    tab_a_q;
  logic [PROD_W-1:0]   prod_q;
  logic [PROB_W-1:0]   p_q;
  logic [22:0]         f_q;
  logic [BIT_W-1:0]    b_q;
  logic [LOSS_W-1:0]   lval_q;
  logic [ACC_W-1:0]    acc_q;
  logic [SUM_W-1:0]    sum_q;
  logic [COUNT_W-1:0]  count_q;
  logic                sat_q;
  logic [SUM_W-1:0]    quo_q;
  logic [COUNT_W:0]    rem_q;
  logic [COUNT_W-1:0]  div_n_q;
  logic                out_valid_q;
  logic [MEAN_W-1:0]   mean_q;
  logic [COUNT_W-1:0]  seen_q;
  logic                osat_q;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      logit_q <= 1'b0;
    end else if (cfg_valid_i) begin
      logit_q <= cfg_data_i;
    end
  end

  // Sigmoid table lookup
  logic [PRED_W-1:0] a_abs;
  logic [IDX_W-1:0]  s_idx;
  logic [TAB_W-1:0]  s_ta, s_tb, s_diff;
  assign a_abs  = pred_q[PRED_W-1] ? PRED_W'(-pred_q) : pred_q;
  assign s_idx  = a_abs[19:12];
  assign s_ta   = SIG_TAB[s_idx];
  assign s_tb   = SIG_TAB[{1'b0, s_idx} + 9'd1];
  assign s_diff = (s_tb >= s_ta) ? s_tb - s_ta : '0;

  // Probability and clamp
  logic [TAB_W-1:0] s_int, s_abs, s_sgn, p_logit, p_prob, p_new;
  always_comb begin
    s_int = tab_a_q + TAB_W'((prod_q + PROD_W'(2048)) >> 12);
    if (a_abs >= SIG_SPAN) s_abs = ONE_Q24;
    else if (s_int > ONE_Q24) s_abs = ONE_Q24;
    else s_abs = s_int;
    s_sgn = pred_q[PRED_W-1] ? ONE_Q24 - s_abs : s_abs;
    if (s_sgn < EPS_Q24)       p_logit = EPS_Q24;
    else if (s_sgn > PMAX_Q24) p_logit = PMAX_Q24;
    else                       p_logit = s_sgn;
    if (pred_q[PRED_W-1] || pred_q == '0) p_prob = EPS_Q24;
    else if (pred_q >= PRED_W'(65536))    p_prob = PMAX_Q24;
    else                                  p_prob = {1'b0, pred_q[15:0], 8'd0};
    p_new = logit_q ? p_logit : p_prob;
  end

  // Leading one and normalise
  logic [PROB_W-1:0] op;
  logic [BIT_W-1:0]  lead;
  logic [PROB_W-1:0] op_sh;
  always_comb begin
    op   = cmd_i.sel ? PROB_W'(ONE_Q24 - {1'b0, p_q}) : p_q;
    lead = '0;
    for (int i = 1; i < PROB_W; i++) begin
      if (op[i]) lead = BIT_W'(i);
    end
    op_sh = op << (BIT_W'(23) - lead);
  end

  // Log table lookup
  logic [IDX_W-1:0] l_idx;
  logic [TAB_W-1:0] l_ta, l_tb, l_diff;
  assign l_idx  = f_q[22:15];
  assign l_ta   = LN_TAB[l_idx];
  assign l_tb   = LN_TAB[{1'b0, l_idx} + 9'd1];
  assign l_diff = (l_tb >= l_ta) ? l_tb - l_ta : '0;

  // Finish -ln
  logic [TAB_W-1:0] lnm;
  logic [28:0]      v, vd;
  logic [28:0]      vr;
  always_comb begin
    lnm = tab_a_q + TAB_W'((prod_q + PROD_W'(16384)) >> 15);
    v   = 29'(BIT_W'(24) - b_q) * 29'(LN2_Q24);
    vd  = (v > 29'(lnm)) ? v - 29'(lnm) : '0;
    vr  = vd + 29'd128;
  end

  // Weighted term
  logic [LABEL_W-1:0] w;
  logic [ACC_W-1:0]   term;
  assign w    = cmd_i.sel ? LABEL_ONE - label_q : label_q;
  assign term = ACC_W'(w) * ACC_W'(lval_q);

  // Division step
  logic [COUNT_W:0] r_sh;
  logic             q_bit;
  assign r_sh  = {rem_q[COUNT_W-1:0], quo_q[SUM_W-1]};
  assign q_bit = r_sh >= {1'b0, div_n_q};

  logic [COUNT_W-1:0] n_eff;
  assign n_eff = (count_q == '0) ? COUNT_W'(1) : count_q;

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      label_q <= (label_i > LABEL_ONE) ? LABEL_ONE : label_i;
      pred_q  <= prediction_i;
      last_q  <= last_element_i;
    end
    if (cmd_i.sig) begin
      tab_a_q <= s_ta;
      prod_q  <= PROD_W'(s_diff) * PROD_W'(a_abs[11:0]);
    end
    if (cmd_i.prob) p_q <= PROB_W'(p_new);
    if (cmd_i.norm) begin
      f_q <= op_sh[22:0];
      b_q <= lead;
    end
    if (cmd_i.lmul) begin
      tab_a_q <= l_ta;
      prod_q  <= PROD_W'(l_diff) * PROD_W'(f_q[14:0]);
    end
    if (cmd_i.lfin) lval_q <= LOSS_W'(vr >> 8);
    if (cmd_i.wmul) acc_q <= cmd_i.sel ? acc_q + term : term;
    if (cmd_i.div_init) begin
      quo_q   <= sum_q + SUM_W'(n_eff >> 1);
      rem_q   <= '0;
      div_n_q <= n_eff;
    end
    if (cmd_i.div_step) begin
      quo_q <= {quo_q[SUM_W-2:0], q_bit};
      rem_q <= q_bit ? r_sh - {1'b0, div_n_q} : r_sh;
    end
    if (cmd_i.emit) begin
      mean_q <= quo_q[MEAN_W-1:0];
      seen_q <= count_q;
      osat_q <= sat_q;
    end
  end

  // Running sum, count and saturation flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      sat_q   <= 1'b0;
    end else if (cmd_i.emit) begin
      sum_q   <= '0;
      count_q <= '0;
      sat_q   <= 1'b0;
    end else begin
      if (cmd_i.acc) begin
        sum_q   <= sum_q + SUM_W'((acc_q + ACC_W'(32768)) >> 16);
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.mark_sat) sat_q <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.count_full = count_q >= MAX_COUNT;
  assign status_o.last       = last_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign mean_loss_o       = mean_q;
  assign elements_seen_o   = seen_q;
  assign count_saturated_o = osat_q;

endmodule

### design/bce_mean_loss.sv
// Streaming mean binary cross entropy. Each accepted (label, prediction)
// transaction is turned into a probability (through a sigmoid table when
// logit mode is set, clamped to [2^-23, 1-2^-23]), its loss is formed from a
// ln(1+f) table with linear interpolation for both the p and 1-p terms on one
// shared lookup-and-multiply path, and the loss is added to a running sum. An
// element runs sigmoid and probability, then normalise, log multiply, log
// finish and weight multiply for p and for 1-p, then accumulate, before the
// next is accepted (at the count limit it stops after probability). The last
// element adds a 42-step restoring divider for sum/count; the output register
// holds one result, so the next set can start while it waits to be taken.
// The configuration port is always ready; write logit mode only while idle.
module bce_mean_loss
  import bce_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [LABEL_W-1:0] label_i,
  input  logic [PRED_W-1:0]  prediction_i,
  input  logic               last_element_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [MEAN_W-1:0]  mean_loss_o,
  output logic [COUNT_W-1:0] elements_seen_o,
  output logic               count_saturated_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  bce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bce_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .label_i           (label_i),
    .prediction_i      (prediction_i),
    .last_element_i    (last_element_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .mean_loss_o       (mean_loss_o),
    .elements_seen_o   (elements_seen_o),
    .count_saturated_o (count_saturated_o),
    .cmd_i             (cmd),
    .status_o          (status)
  );

endmodule

### design/bce_chk.sv
module bce_chk
  import bce_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [MEAN_W-1:0]  mean_loss_o,
  input logic [COUNT_W-1:0] elements_seen_o,
  input logic               count_saturated_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mean_loss_o)
      && $stable(elements_seen_o) && $stable(count_saturated_o))
    else $error("stalled result changed");

  // Drop ready after each input transaction
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after an input transaction");

  // Every set averages at least one element
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> elements_seen_o != '0)
    else $error("result with zero elements");

  // Saturation only at the count limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && count_saturated_o |-> elements_seen_o == MAX_COUNT)
    else $error("saturation flagged below the count limit");

endmodule

bind bce_mean_loss bce_chk u_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .mean_loss_o       (mean_loss_o),
  .elements_seen_o   (elements_seen_o),
  .count_saturated_o (count_saturated_o)
);
